>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define QERC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Concurrent assertion that also holds across reset.
`define QERC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

>>> src/qerc_pkg.sv
// ----------------------------------------------------------------------------
// qerc_pkg
// Shared types and constants of the quadrature encoder rate counter.
// ----------------------------------------------------------------------------
package qerc_pkg;

   // Field widths.
   localparam int SampleWidth = 10;
   localparam int SettleWidth = 4;
   localparam int WindowWidth = 8;
   localparam int CountWidth  = 8;
   localparam int CodeWidth   = 2;

   // Request and response bus widths (padded to whole bytes).
   localparam int ReqDataWidth = 24;
   localparam int RspDataWidth = 8;

   // Configuration port.
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 10;

   localparam logic [CsrIndexWidth-1:0] RegThreshold = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegSettle    = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegWindow    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [SampleWidth-1:0] ThresholdReset = 10'd500;
   localparam logic [SettleWidth-1:0] SettleReset    = 4'd2;
   localparam logic [WindowWidth-1:0] WindowReset    = 8'd100;

   // Encoder code after reset: both lines high.
   localparam logic [CodeWidth-1:0] CodeReset = 2'd3;

   typedef struct packed {
      logic [SampleWidth-1:0] threshold;
      logic [SettleWidth-1:0] settle_ticks;
      logic [WindowWidth-1:0] window_ticks;
   } cfg_type;

   typedef struct packed {
      logic [SampleWidth-1:0] sample_a;
      logic [SampleWidth-1:0] sample_b;
      logic                   clear_value;
   } item_type;

   typedef struct packed {
      logic signed [CountWidth-1:0] count_value;
      logic                         window_done;
   } result_type;

endpackage

>>> src/qerc_csr.sv
// ----------------------------------------------------------------------------
// qerc_csr
// Configuration registers: threshold, settle time and window length.
// ----------------------------------------------------------------------------
module qerc_csr
   import qerc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   output cfg_type                  cfg
);

   logic [SampleWidth-1:0] threshold_ff;
   logic [SettleWidth-1:0] settle_ff;
   logic [WindowWidth-1:0] window_ff;

   // Register writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         settle_ff    <= SettleReset;
         window_ff    <= WindowReset;
      end else if (csr_we) begin
         case (csr_index)
            RegThreshold: begin
               threshold_ff <= csr_wdata[SampleWidth-1:0];
            end
            RegSettle: begin
               settle_ff <= csr_wdata[SettleWidth-1:0];
            end
            RegWindow: begin
               window_ff <= csr_wdata[WindowWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.threshold    = threshold_ff;
   assign cfg.settle_ticks = settle_ff;
   assign cfg.window_ticks = window_ff;

endmodule

>>> src/qerc_core.sv
// ----------------------------------------------------------------------------
// qerc_core
// Per-tick state update: window counter, debounce phase and step counting.
// ----------------------------------------------------------------------------
module qerc_core
   import qerc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  cfg_type    cfg,
   input  item_type   item,
   output result_type result
);

   typedef enum logic [1:0] {
      PH_WAIT    = 2'd0,
      PH_CONFIRM = 2'd1,
      PH_AFTER   = 2'd2
   } phase_type;

   // Quadrature direction: +1 forward, -1 backward, 0 for a double jump.
   function automatic logic [CountWidth-1:0] step_delta(
      input logic [CodeWidth-1:0] from_code,
      input logic [CodeWidth-1:0] to_code
   );
      logic [CodeWidth-1:0] fwd;
      logic [CodeWidth-1:0] bwd;
      begin
         case (from_code)
            2'd0: begin fwd = 2'd1; bwd = 2'd2; end
            2'd1: begin fwd = 2'd3; bwd = 2'd0; end
            2'd2: begin fwd = 2'd0; bwd = 2'd3; end
            default: begin fwd = 2'd2; bwd = 2'd1; end
         endcase
         if (to_code == fwd) begin
            step_delta = {{(CountWidth-1){1'b0}}, 1'b1};
         end else if (to_code == bwd) begin
            step_delta = {CountWidth{1'b1}};
         end else begin
            step_delta = '0;
         end
      end
   endfunction

   logic [CodeWidth-1:0]   stable_ff, stable_in;
   logic [CodeWidth-1:0]   cand_ff, cand_in;
   phase_type              phase_ff, phase_in;
   logic [SettleWidth-1:0] settle_ff, settle_in;
   logic [CountWidth-1:0]  acc_ff, acc_in;
   logic [CountWidth-1:0]  reported_ff, reported_in;
   logic [WindowWidth-1:0] wcount_ff, wcount_in;

   logic [CodeWidth-1:0]   code;
   logic [WindowWidth-1:0] wcount_sum;
   logic [WindowWidth-1:0] window_eff;
   logic                   done;
   logic [CountWidth-1:0]  acc_mid;
   logic [CountWidth-1:0]  report;

   // Line levels against the threshold; A in bit 0, B in bit 1.
   assign code = {item.sample_b > cfg.threshold, item.sample_a > cfg.threshold};

   // Window check first, then the debounce phase.
   always_comb begin
      wcount_sum = wcount_ff + 1'b1;
      window_eff = (cfg.window_ticks == '0) ? {{(WindowWidth-1){1'b0}}, 1'b1}
                                            : cfg.window_ticks;
      done = (wcount_sum >= window_eff);

      if (done) begin
         report    = acc_ff;
         acc_mid   = '0;
         wcount_in = '0;
      end else begin
         report    = reported_ff;
         acc_mid   = acc_ff;
         wcount_in = wcount_sum;
      end

      stable_in = stable_ff;
      cand_in   = cand_ff;
      phase_in  = phase_ff;
      settle_in = settle_ff;
      acc_in    = acc_mid;

      case (phase_ff)
         PH_CONFIRM, PH_AFTER: begin
            if (settle_ff > {{(SettleWidth-1){1'b0}}, 1'b1}) begin
               settle_in = settle_ff - 1'b1;
            end else if (phase_ff == PH_CONFIRM) begin
               // Confirm only if the code held still and is a real change.
               if (code == cand_ff && cand_ff != stable_ff) begin
                  acc_in    = acc_mid + step_delta(stable_ff, cand_ff);
                  stable_in = cand_ff;
               end
               settle_in = cfg.settle_ticks;
               phase_in  = PH_AFTER;
            end else begin
               phase_in = PH_WAIT;
            end
         end
         default: begin
            cand_in = code;
            if (code != stable_ff) begin
               settle_in = cfg.settle_ticks;
               phase_in  = PH_CONFIRM;
            end else begin
               phase_in = PH_WAIT;
            end
         end
      endcase

      // The clear takes effect after this tick's report.
      reported_in = item.clear_value ? '0 : report;
   end

   assign result.count_value = report;
   assign result.window_done = done;

   // State advances once per tick that moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff   <= CodeReset;
         cand_ff     <= CodeReset;
         phase_ff    <= PH_WAIT;
         settle_ff   <= '0;
         acc_ff      <= '0;
         reported_ff <= '0;
         wcount_ff   <= '0;
      end else if (enable) begin
         stable_ff   <= stable_in;
         cand_ff     <= cand_in;
         phase_ff    <= phase_in;
         settle_ff   <= settle_in;
         acc_ff      <= acc_in;
         reported_ff <= reported_in;
         wcount_ff   <= wcount_in;
      end
   end

endmodule

>>> src/quadrature_encoder_rate_counter.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_rate_counter
// Debounced quadrature decoder that reports net steps per counting window.
// ----------------------------------------------------------------------------
// Each request is one tick carrying two analog line samples and a clear flag,
// and produces exactly one response with the reported count and a window-end
// flag on tlast. The block takes one request per clock cycle while the
// response side is not stalled. A request is held in the input register, the
// tick's state update and result are formed between that register and the
// result register, and the response is shown from the result register.
// The result register decouples the sides, so a new request is taken while a
// finished response waits. Configuration is written through the csr port.
module quadrature_encoder_rate_counter
   import qerc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request stream.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // req_tdata: sample_a [9:0], sample_b [19:10], clear_value [20], zero pad
   input  logic [ReqDataWidth-1:0]  req_tdata,
   // Response stream.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rsp_tdata: count_value [7:0]
   output logic [RspDataWidth-1:0]  rsp_tdata,
   output logic                     rsp_tlast,
   // Configuration writes.
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff;
   result_type result;
   logic       in_valid_ff;
   logic       out_valid_ff;
   logic [CountWidth-1:0] count_ff;
   logic       done_ff;
   logic       advance;

   qerc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The held request moves on when the result register is free or draining.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.sample_a    <= req_tdata[SampleWidth-1:0];
         item_ff.sample_b    <= req_tdata[2*SampleWidth-1:SampleWidth];
         item_ff.clear_value <= req_tdata[2*SampleWidth];
      end
   end

   qerc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .enable (advance),
      .cfg    (cfg),
      .item   (item_ff),
      .result (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         count_ff <= result.count_value;
         done_ff  <= result.window_done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = count_ff;
   assign rsp_tlast  = done_ff;

endmodule

>>> src/qerc_checker.sv
// ----------------------------------------------------------------------------
// qerc_checker
// Port-level checks of the rate counter's request and response streams.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qerc_checker
   import qerc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataWidth-1:0] rsp_tdata,
   input logic                    rsp_tlast
);

   // No response is left over from before reset.
   `QERC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // A stalled response holds its value.
   `QERC_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Requests are only refused while a response is waiting and stalled.
   `QERC_ASSERT(a_stall_cause, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready)

   // Every accepted request is followed by a response shown from the result register.
   `QERC_ASSERT(a_rsp_latency, clock, reset, req_tvalid && req_tready |-> ##2 rsp_tvalid)

endmodule

bind quadrature_encoder_rate_counter qerc_checker u_qerc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/tb_quadrature_encoder_rate_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_rate_counter
// Self-checking testbench for the quadrature encoder rate counter.
// ----------------------------------------------------------------------------
// Tick requests are queued by the stimulus process and sent by a driver with
// random gaps. Each accepted tick runs through a predictor that tracks the
// debounce phase, the step count and the window. The expected report is then
// queued. A monitor with random stalls compares every response with the oldest
// expected report. The stimulus is a short directed tour of every quadrature
// transition, followed by phases of random encoder walks, each with its own
// register settings. The settings include the extremes of every register.
// ----------------------------------------------------------------------------
module tb_quadrature_encoder_rate_counter;
   import qerc_pkg::*;

   localparam int SampleMax    = (1 << SampleWidth) - 1;
   localparam int HoldMax      = 14;
   localparam int QuietLimit   = 2000;
   localparam int PhaseTicks   = 140;
   localparam int RandomPhases = 12;

   // Codes visited by the directed tour, first code in the lowest bits: four
   // forward steps, a jump across, then four backward steps.
   localparam logic [17:0] DirectedTour =
      {2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd0, 2'd2};

   typedef enum logic [1:0] {
      EncWait    = 2'd0,
      EncConfirm = 2'd1,
      EncAfter   = 2'd2
   } enc_phase_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // req_tdata: sample_a [9:0], sample_b [19:10], clear_value [20], zero pad
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // rsp_tdata: count_value [7:0]
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_wdata = '0;

   item_type   pending_ticks[$];
   result_type expected_reports[$];
   item_type   shown_tick;
   int         gap_left = 0;
   int         stall_left = 0;
   int         quiet_cycles = 0;
   int         error_count = 0;
   bit         sender_idles = 1'b0;
   bit         receiver_stalls = 1'b0;
   logic [CodeWidth-1:0] walk_code = CodeReset;

   // Predictor copy of the registers and of the decoder state.
   cfg_type                model_cfg;
   logic [CodeWidth-1:0]   stable_code;
   logic [CodeWidth-1:0]   candidate_code;
   enc_phase_type          enc_phase;
   logic [SettleWidth-1:0] settle_left;
   logic [CountWidth-1:0]  step_total;
   logic [CountWidth-1:0]  reported_total;
   logic [WindowWidth-1:0] window_ticks_seen;

   quadrature_encoder_rate_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Advances the predicted decoder by one tick and returns its report.
   function automatic result_type predict_tick(input item_type t);
      result_type           r;
      logic [CodeWidth-1:0] code;
      code = {t.sample_b > model_cfg.threshold, t.sample_a > model_cfg.threshold};
      r.window_done = 1'b0;

      // Window check comes first, so a step on this tick lands in the next window.
      window_ticks_seen = window_ticks_seen + 1'b1;
      if (window_ticks_seen >= model_cfg.window_ticks) begin
         reported_total = step_total;
         step_total = '0;
         window_ticks_seen = '0;
         r.window_done = 1'b1;
      end

      // A settle time of zero ends the wait on the next tick, just as one does.
      case (enc_phase)
         EncConfirm, EncAfter: begin
            if (settle_left > 1) begin
               settle_left = settle_left - 1'b1;
            end else if (enc_phase == EncConfirm) begin
               if (code == candidate_code && candidate_code != stable_code) begin
                  // Gray order 0-1-3-2 counts up; a jump across counts nothing.
                  case ({stable_code, candidate_code})
                     4'b00_01, 4'b01_11, 4'b11_10, 4'b10_00: step_total = step_total + 1'b1;
                     4'b00_10, 4'b10_11, 4'b11_01, 4'b01_00: step_total = step_total - 1'b1;
                     default: ;
                  endcase
                  stable_code = candidate_code;
               end
               settle_left = model_cfg.settle_ticks;
               enc_phase = EncAfter;
            end else begin
               enc_phase = EncWait;
            end
         end
         default: begin
            candidate_code = code;
            if (code != stable_code) begin
               settle_left = model_cfg.settle_ticks;
               enc_phase = EncConfirm;
            end else begin
               enc_phase = EncWait;
            end
         end
      endcase

      r.count_value = reported_total;
      if (t.clear_value) reported_total = '0;
      return r;
   endfunction

   // Request driver: presents queued ticks, with a random gap drawn per tick.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_reports.push_back(predict_tick(shown_tick));
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               shown_tick = pending_ticks.pop_front();
               req_tdata <= ReqDataWidth'({shown_tick.clear_value, shown_tick.sample_b,
                                           shown_tick.sample_a});
               req_tvalid <= 1'b1;
               gap_left = sender_idles ? $urandom_range(0, HoldMax) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each report and stalls at random after it.
   always @(posedge clock) begin : report_check
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_reports.size() == 0) begin
               $error("response with no request pending: count_value %0d",
                      $signed(rsp_tdata[CountWidth-1:0]));
               error_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_tdata[CountWidth-1:0] !== want.count_value) begin
                  $error("count_value: expected %0d, actual %0d", want.count_value,
                         $signed(rsp_tdata[CountWidth-1:0]));
                  error_count++;
               end
               if (rsp_tlast !== want.window_done) begin
                  $error("window_done: expected %0d, actual %0d", want.window_done,
                         rsp_tlast);
                  error_count++;
               end
            end
            stall_left = receiver_stalls ? $urandom_range(0, HoldMax) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: ends the run when neither side moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Writes one register and mirrors it into the predictor.
   task automatic write_reg(input logic [CsrIndexWidth-1:0] index, input int unsigned value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= CsrDataWidth'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         RegThreshold: model_cfg.threshold = SampleWidth'(value);
         RegSettle:    model_cfg.settle_ticks = SettleWidth'(value);
         RegWindow:    model_cfg.window_ticks = WindowWidth'(value);
         default: ;
      endcase
   endtask

   // Waits until every tick has been sent and every report has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_ticks.size() != 0 || req_tvalid || expected_reports.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // A sample that reads as the given line level under the current threshold.
   function automatic logic [SampleWidth-1:0] line_sample(input logic level);
      int unsigned thr;
      thr = 32'(model_cfg.threshold);
      if (level && thr < SampleMax) begin
         if ($urandom_range(0, 7) == 0) return SampleWidth'(thr + 1);
         return SampleWidth'($urandom_range(thr + 1, SampleMax));
      end
      if ($urandom_range(0, 7) == 0) return SampleWidth'(thr);
      return SampleWidth'($urandom_range(0, thr));
   endfunction

   // Queues a run of ticks that all read as one code.
   task automatic hold_code(input logic [CodeWidth-1:0] code, input int ticks);
      item_type t;
      repeat (ticks) begin
         t.sample_a = line_sample(code[0]);
         t.sample_b = line_sample(code[1]);
         t.clear_value = ($urandom_range(0, 9) == 0);
         pending_ticks.push_back(t);
      end
   endtask

   // Queues a random encoder walk: mostly clean steps held long enough to be
   // confirmed, with jumps, short glitches, early changes and raw noise mixed in.
   task automatic run_random_phase(input int ticks);
      int       settle;
      int       pick;
      int       dwell;
      bit       forward;
      item_type t;
      settle = (model_cfg.settle_ticks == 0) ? 1 : model_cfg.settle_ticks;
      while (pending_ticks.size() < ticks) begin
         pick = $urandom_range(0, 99);
         dwell = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * settle)
                                             : 2 * settle + 1 + $urandom_range(0, 2);
         if (pick < 70) begin
            forward = 1'($urandom_range(0, 1));
            case (walk_code)
               2'd0:    walk_code = forward ? 2'd1 : 2'd2;
               2'd1:    walk_code = forward ? 2'd3 : 2'd0;
               2'd3:    walk_code = forward ? 2'd2 : 2'd1;
               default: walk_code = forward ? 2'd0 : 2'd3;
            endcase
            hold_code(walk_code, dwell);
         end else if (pick < 80) begin
            walk_code = walk_code ^ 2'b11;
            hold_code(walk_code, dwell);
         end else if (pick < 90) begin
            // A glitch on one line that is gone before the settle wait ends.
            hold_code(walk_code ^ CodeWidth'(1 << $urandom_range(0, 1)),
                      $urandom_range(1, settle));
            hold_code(walk_code, 2 * settle + 2);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               t.sample_a = SampleWidth'($urandom_range(0, SampleMax));
               t.sample_b = SampleWidth'($urandom_range(0, SampleMax));
               t.clear_value = 1'($urandom_range(0, 1));
               pending_ticks.push_back(t);
            end
            walk_code = CodeWidth'($urandom_range(0, 3));
            hold_code(walk_code, dwell);
         end
      end
   endtask

   initial begin : stimulus
      item_type             t;
      logic [CodeWidth-1:0] code;
      model_cfg.threshold = ThresholdReset;
      model_cfg.settle_ticks = SettleReset;
      model_cfg.window_ticks = WindowReset;
      stable_code = CodeReset;
      candidate_code = CodeReset;
      enc_phase = EncWait;
      settle_left = '0;
      step_total = '0;
      reported_total = '0;
      window_ticks_seen = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed tour with zero settle time and a short window, at the reset
      // threshold: samples at the range ends and right at the threshold.
      write_reg(RegSettle, 0);
      write_reg(RegWindow, 3);
      for (int i = 0; i < 9; i++) begin
         code = DirectedTour[2 * i +: 2];
         for (int k = 0; k < 3; k++) begin
            t.sample_a = SampleWidth'(code[0] ? ((k == 1) ? SampleMax : ThresholdReset + 1)
                                              : ((k == 1) ? 0 : ThresholdReset));
            t.sample_b = SampleWidth'(code[1] ? ((k == 2) ? SampleMax : ThresholdReset + 1)
                                              : ((k == 2) ? 0 : ThresholdReset));
            t.clear_value = (k == 2 && i % 3 == 1);
            pending_ticks.push_back(t);
         end
      end
      walk_code = DirectedTour[17:16];

      // Random phases, each with fresh register settings and idling style.
      for (int p = 0; p < RandomPhases; p++) begin
         wait_idle();
         case (p)
            0: begin
               write_reg(RegSettle, SettleReset);
               write_reg(RegWindow, WindowReset);
            end
            1: begin
               write_reg(RegThreshold, 0);
               write_reg(RegSettle, 0);
               write_reg(RegWindow, 0);
            end
            2: begin
               write_reg(RegThreshold, SampleMax);
               write_reg(RegSettle, 15);
               write_reg(RegWindow, 255);
            end
            3: begin
               write_reg(RegThreshold, $urandom_range(1, SampleMax - 1));
               write_reg(RegSettle, 1);
               write_reg(RegWindow, 1);
            end
            default: begin
               write_reg(RegThreshold, $urandom_range(0, SampleMax));
               write_reg(RegSettle, $urandom_range(0, 15));
               write_reg(RegWindow, $urandom_range(0, 255));
            end
         endcase
         sender_idles = (p != 0) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (p != 0) && ($urandom_range(0, 3) != 0);
         run_random_phase(PhaseTicks);
      end

      // Let every report drain, then allow for any stray response.
      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
